// File: hdl/mixed_radix_factorizer_core_macros.svh
// Assertion helpers used by the checker file of the factorizer.
`ifndef MIXED_RADIX_FACTORIZER_CORE_MACROS_SVH
`define MIXED_RADIX_FACTORIZER_CORE_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define MRF_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Common form on the block clock and reset.
`define MRF_ASSERT(lbl, prop, msg) \
  `MRF_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: hdl/mrf_pkg.sv
package mrf_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int RADIX_W     = 4;
  localparam int CNT_W       = 4;
  localparam int MAX_RESULTS = 16;
  localparam int EMIT_W      = $clog2(MAX_RESULTS);
  localparam int KIND_NUM    = 6;

  // Factor kinds in the order in which results leave the block.
  typedef enum logic [2:0] {
    K2 = 3'd0,
    K3 = 3'd1,
    K4 = 3'd2,
    K5 = 3'd3,
    K6 = 3'd4,
    K8 = 3'd5
  } kind_e;

  typedef struct packed {
    logic                   hit;
    logic [LENGTH_BITS-1:0] quot;
  } div_res_t;

  // Multiplicative inverse of an odd number modulo 2^LENGTH_BITS (Newton steps).
  function automatic logic [LENGTH_BITS-1:0] inv_odd(input int d);
    logic [LENGTH_BITS-1:0] x;
    logic [LENGTH_BITS-1:0] dd;
    dd = LENGTH_BITS'(d);
    x  = dd;
    for (int i = 0; i < 5; i++) begin
      x = x * (LENGTH_BITS'(2) - dd * x);
    end
    return x;
  endfunction

  localparam logic [LENGTH_BITS-1:0] INV3 = inv_odd(3);
  localparam logic [LENGTH_BITS-1:0] INV5 = inv_odd(5);
  localparam logic [LENGTH_BITS-1:0] LIM3 = LENGTH_BITS'({LENGTH_BITS{1'b1}} / 3);
  localparam logic [LENGTH_BITS-1:0] LIM5 = LENGTH_BITS'({LENGTH_BITS{1'b1}} / 5);

  function automatic logic [RADIX_W-1:0] radix_of(input kind_e k);
    logic [RADIX_W-1:0] r;
    unique case (k)
      K2:      r = RADIX_W'(2);
      K3:      r = RADIX_W'(3);
      K4:      r = RADIX_W'(4);
      K5:      r = RADIX_W'(5);
      K6:      r = RADIX_W'(6);
      K8:      r = RADIX_W'(8);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Stripping order: sixes, one eight, fives, fours, threes, one two.
  function automatic kind_e next_stage(input kind_e k);
    kind_e n;
    unique case (k)
      K6:      n = K8;
      K8:      n = K5;
      K5:      n = K4;
      K4:      n = K3;
      K3:      n = K2;
      default: n = K2;
    endcase
    return n;
  endfunction

endpackage

// File: hdl/mrf_ifs.sv
interface mrf_len_if;
  logic                            valid;
  logic                            ready;
  logic [mrf_pkg::LENGTH_BITS-1:0] length_value;

  modport source (output valid, output length_value, input ready);
  modport sink   (input valid, input length_value, output ready);
endinterface

interface mrf_fac_if;
  logic                            valid;
  logic                            ready;
  logic [mrf_pkg::RADIX_W-1:0]     radix;
  logic                            last_factor;
  logic [mrf_pkg::LENGTH_BITS-1:0] leftover;

  modport source (output valid, output radix, output last_factor, output leftover,
                  input ready);
  modport sink   (input valid, input radix, input last_factor, input leftover,
                  output ready);
endinterface

// File: hdl/mrf_div_unit.sv
// Tests whether a value is divisible by one factor kind and gives the exact quotient.
// Odd factors use multiplication by the modular inverse: the product is the
// quotient exactly when it does not exceed (2^N - 1) / d.
module mrf_div_unit (
  input  logic [mrf_pkg::LENGTH_BITS-1:0] value_i,
  input  mrf_pkg::kind_e                  kind_i,
  output mrf_pkg::div_res_t               res_o
);

  logic [mrf_pkg::LENGTH_BITS-1:0] op;
  logic [mrf_pkg::LENGTH_BITS-1:0] inv;
  logic [mrf_pkg::LENGTH_BITS-1:0] prod;
  logic                            nonzero;

  assign op      = (kind_i == mrf_pkg::K6) ? (value_i >> 1) : value_i;
  assign inv     = (kind_i == mrf_pkg::K5) ? mrf_pkg::INV5 : mrf_pkg::INV3;
  assign prod    = op * inv;
  assign nonzero = (value_i != '0);

  always_comb begin
    unique case (kind_i)
      mrf_pkg::K2: begin
        res_o.hit  = nonzero && (value_i[0] == 1'b0);
        res_o.quot = value_i >> 1;
      end
      mrf_pkg::K4: begin
        res_o.hit  = nonzero && (value_i[1:0] == 2'b00);
        res_o.quot = value_i >> 2;
      end
      mrf_pkg::K8: begin
        res_o.hit  = nonzero && (value_i[2:0] == 3'b000);
        res_o.quot = value_i >> 3;
      end
      mrf_pkg::K3: begin
        res_o.hit  = nonzero && (prod <= mrf_pkg::LIM3);
        res_o.quot = prod;
      end
      mrf_pkg::K5: begin
        res_o.hit  = nonzero && (prod <= mrf_pkg::LIM5);
        res_o.quot = prod;
      end
      mrf_pkg::K6: begin
        res_o.hit  = nonzero && (value_i[0] == 1'b0) && (prod <= mrf_pkg::LIM3);
        res_o.quot = prod;
      end
      default: begin
        res_o.hit  = 1'b0;
        res_o.quot = value_i;
      end
    endcase
  end

endmodule

// File: hdl/mixed_radix_factorizer_core.sv
//  Channel   Direction  Transfer carries
//  len_if_i  in         length_value (24 bits)
//  fac_if_o  out        radix (4), last_factor (1), leftover (24)
//
//  A length is stripped stage by stage, one factor per hit, through the six
//  stripping stages, and its results then leave one per free output slot.
//  The shared divisibility unit, one test per cycle, sets the pace of stripping.
//  Reset is asynchronous and active low; it returns the block to idle with no result.
//  Results leave through an output register; a stalled result holds, and the
//  block stays busy until its last result is loaded into that register.
module mixed_radix_factorizer_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  mrf_len_if.sink         len_if_i,
  mrf_fac_if.source       fac_if_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STRIP,
    ST_EMIT
  } state_e;

  state_e                            state_q;
  mrf_pkg::kind_e                    stage_q;
  logic [mrf_pkg::LENGTH_BITS-1:0]   val_q;
  logic [mrf_pkg::CNT_W-1:0]         cnt_q [mrf_pkg::KIND_NUM];
  logic [mrf_pkg::EMIT_W-1:0]        nemit_q;
  logic                              ov_q;
  logic [mrf_pkg::RADIX_W-1:0]       radix_q;
  logic                              last_q;
  logic [mrf_pkg::LENGTH_BITS-1:0]   left_q;

  mrf_pkg::div_res_t                 div_res;
  mrf_pkg::kind_e                    sel_kind;
  logic                              any_nz;
  logic                              more;
  logic                              out_free;

  // The single divisibility unit of the block: one divisibility test per cycle on the
  // running value, for the factor kind of the current stage.
  mrf_div_unit u_div (
    .value_i (val_q),
    .kind_i  (stage_q),
    .res_o   (div_res)
  );

  assign len_if_i.ready       = (state_q == ST_IDLE);
  assign fac_if_o.valid       = ov_q;
  assign fac_if_o.radix       = radix_q;
  assign fac_if_o.last_factor = last_q;
  assign fac_if_o.leftover    = left_q;

  assign out_free = !ov_q || fac_if_o.ready;

  // Pick the smallest factor kind that still has results to give, and find out
  // whether any result would follow the one picked.
  always_comb begin
    sel_kind = mrf_pkg::K2;
    any_nz   = 1'b0;
    for (int k = mrf_pkg::KIND_NUM - 1; k >= 0; k--) begin
      if (cnt_q[k] != '0) begin
        sel_kind = mrf_pkg::kind_e'(k);
        any_nz   = 1'b1;
      end
    end
    more = (cnt_q[sel_kind] > mrf_pkg::CNT_W'(1));
    for (int k = 0; k < mrf_pkg::KIND_NUM; k++) begin
      if ((cnt_q[k] != '0) && (mrf_pkg::kind_e'(k) != sel_kind)) begin
        more = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stage_q <= mrf_pkg::K6;
      val_q   <= '0;
      nemit_q <= '0;
      ov_q    <= 1'b0;
      radix_q <= '0;
      last_q  <= 1'b0;
      left_q  <= '0;
      for (int k = 0; k < mrf_pkg::KIND_NUM; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      // Outside the emit state a taken result simply empties the register;
      // the emit state refills or empties it on its own.
      if (ov_q && fac_if_o.ready && state_q != ST_EMIT) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (len_if_i.valid) begin
            val_q   <= len_if_i.length_value;
            stage_q <= mrf_pkg::K6;
            state_q <= ST_STRIP;
            for (int k = 0; k < mrf_pkg::KIND_NUM; k++) begin
              cnt_q[k] <= '0;
            end
          end
        end
        ST_STRIP: begin
          // A hit strips one factor. The eight and the two are taken at most
          // once, so those stages move on right after a hit. A length of zero
          // never hits, which leaves all counts at zero.
          if (div_res.hit) begin
            val_q <= div_res.quot;
            if (cnt_q[stage_q] != {mrf_pkg::CNT_W{1'b1}}) begin
              cnt_q[stage_q] <= cnt_q[stage_q] + mrf_pkg::CNT_W'(1);
            end
          end
          if (!div_res.hit || stage_q == mrf_pkg::K8 || stage_q == mrf_pkg::K2) begin
            if (stage_q == mrf_pkg::K2) begin
              state_q <= ST_EMIT;
              nemit_q <= '0;
            end else begin
              stage_q <= mrf_pkg::next_stage(stage_q);
            end
          end
        end
        ST_EMIT: begin
          // One result per free slot in the output register. With no factor at
          // all a single result of radix zero closes the run.
          if (out_free) begin
            ov_q    <= 1'b1;
            left_q  <= val_q;
            nemit_q <= nemit_q + mrf_pkg::EMIT_W'(1);
            if (any_nz) begin
              radix_q         <= mrf_pkg::radix_of(sel_kind);
              cnt_q[sel_kind] <= cnt_q[sel_kind] - mrf_pkg::CNT_W'(1);
            end else begin
              radix_q <= '0;
            end
            if (!more || !any_nz || nemit_q == {mrf_pkg::EMIT_W{1'b1}}) begin
              last_q  <= 1'b1;
              state_q <= ST_IDLE;
            end else begin
              last_q  <= 1'b0;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/mrf_checker.sv
`include "mixed_radix_factorizer_core_macros.svh"

module mrf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [mrf_pkg::RADIX_W-1:0]     radix_i,
  input logic                            last_factor_i,
  input logic [mrf_pkg::LENGTH_BITS-1:0] leftover_i
);

  // A waiting result must not change under the sink.
  `MRF_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(radix_i) && $stable(last_factor_i) && $stable(leftover_i), "stalled result changed")

  // The block works on one length at a time.
  `MRF_ASSERT(a_busy_after_accept, in_valid_i && in_ready_i |=> !in_ready_i, "ready right after a transfer")

  `MRF_ASSERT(a_radix_legal, out_valid_i |-> radix_i == 0 || radix_i == 2 || radix_i == 3 || radix_i == 4 || radix_i == 5 || radix_i == 6 || radix_i == 8, "illegal radix")

  // No factor or a zero length always gives a single closing result.
  `MRF_ASSERT(a_zero_is_last, out_valid_i && radix_i == 0 |-> last_factor_i, "radix zero not last")

  // While a run still has results to come, no new length is taken.
  `MRF_ASSERT(a_no_accept_mid_run, out_valid_i && !last_factor_i |-> !in_ready_i, "ready in the middle of a run")

endmodule

bind mixed_radix_factorizer_core mrf_checker u_mrf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (len_if_i.valid),
  .in_ready_i    (len_if_i.ready),
  .out_valid_i   (fac_if_o.valid),
  .out_ready_i   (fac_if_o.ready),
  .radix_i       (fac_if_o.radix),
  .last_factor_i (fac_if_o.last_factor),
  .leftover_i    (fac_if_o.leftover)
);
